[hw/rtl/pressure_sensor_compensation_core_defines.svh]
// Assertion macros for the pressure sensor compensation core.
// Included by files that check their own logic; needs clk and rst in scope.
`ifndef PRESSURE_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication.
`define PSCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pscc_pkg.sv]
// Constants, types and helper functions for the pressure sensor compensation core.
// No dependencies.
package pscc_pkg;

  localparam int unsigned IN_W      = 24;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned PROM_W    = 16;
  localparam int unsigned N_PROM    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_FSP   = 3'd7;
  localparam logic [CFG_W-1:0]     FSP_RESET = 24'd393216;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // divider geometry
  localparam int unsigned NUM_W     = 61;
  localparam int unsigned DEN_W     = 60;
  localparam int unsigned DIVR_W    = 68;
  localparam int unsigned DIVD_W    = 67;
  localparam int unsigned Q_W       = 33;
  localparam int unsigned DIV_STEPS = 33;

  // pipeline layout
  localparam int unsigned FRONT_ST  = 5;
  localparam int unsigned POST_ST   = 10;
  localparam int unsigned N_ST      = FRONT_ST + DIV_STEPS + POST_ST;
  localparam int unsigned DIV_LAST  = FRONT_ST + DIV_STEPS - 1;

  // ceil(2^32 / 3), exact floor(u/3) for u < 2^31
  localparam logic [30:0] RECIP3 = 31'h5555_5556;
  // half of 3 * 2^32
  localparam logic [63:0] HALF3  = 64'h0000_0001_8000_0000;

  localparam logic signed [32:0] Y_ONE = 33'sd16777216;
  localparam logic signed [36:0] E_OFF = 37'sd16777216;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] temp;
    logic               qneg;
    logic               dz;
    logic               ovf;
  } div_side_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] y;
    logic signed [31:0] p;
    logic               dz;
    logic               sat;
  } post_side_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] val;
  } sat_t;

  // round to nearest, ties away from zero, after an arithmetic right shift
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    rnd_shr = v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > S32_MAX) begin
      s.flag = 1'b1;
      s.val  = 32'sh7fff_ffff;
    end else if (v < S32_MIN) begin
      s.flag = 1'b1;
      s.val  = 32'sh8000_0000;
    end else begin
      s.flag = 1'b0;
      s.val  = v[31:0];
    end
    return s;
  endfunction

endpackage

[hw/rtl/pressure_sensor_compensation_core.sv]
// Pressure sensor compensation core: polynomial temperature and pressure correction.
// Depends on pscc_pkg and pressure_sensor_compensation_core_defines.svh.
//
// Takes one reading item (raw pressure and raw temperature) per clock while
// reading_stall is low, and returns one result item per reading. The ratio y comes from
// a restoring divider that resolves one quotient bit per pipeline stage over 33 stages;
// the five stages before it form the polynomials, and ten after it carry the
// linearisation, full-scale scaling and the result register. The pipeline moves as one:
// while a finished result is stalled, reading_stall is high. The user must keep
// calibration words and full scale static while items are in flight; the block does not enforce it.
`include "pressure_sensor_compensation_core_defines.svh"

module pressure_sensor_compensation_core
  import pscc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  reading_valid,
  output logic                  reading_stall,
  input  logic [IN_W-1:0]       pressure_raw,
  input  logic [IN_W-1:0]       temperature_raw,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [OUT_W-1:0] temperature,
  output logic signed [OUT_W-1:0] ratio_y,
  output logic signed [OUT_W-1:0] normalised_pressure,
  output logic signed [OUT_W-1:0] scaled_pressure,
  output logic [1:0]            status
);

  // configuration
  logic [PROM_W-1:0] prom [N_PROM];
  logic [CFG_W-1:0]  fsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_PROM; i++) prom[i] <= '0;
      fsp <= FSP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FSP) begin
        fsp <= cfg_data;
      end else begin
        prom[cfg_index] <= cfg_data[PROM_W-1:0];
      end
    end
  end

  logic [31:0] w12, w23, w34, w45, w56, w67;
  logic signed [13:0] c0, c1;
  logic signed [9:0]  c2, c3, c4, c5, c6, a0, a1, a2;

  assign w12 = {prom[0], prom[1]};
  assign w23 = {prom[1], prom[2]};
  assign w34 = {prom[2], prom[3]};
  assign w45 = {prom[3], prom[4]};
  assign w56 = {prom[4], prom[5]};
  assign w67 = {prom[5], prom[6]};
  assign c0 = $signed(w12[31:18]);
  assign c1 = $signed(w12[17:4]);
  assign c2 = $signed(w23[19:10]);
  assign c3 = $signed(w34[25:16]);
  assign c4 = $signed(w45[31:22]);
  assign c5 = $signed(w45[21:12]);
  assign c6 = $signed(w56[27:18]);
  assign a0 = $signed(w56[17:8]);
  assign a1 = $signed(w67[23:14]);
  assign a2 = $signed(w67[13:4]);

  // pipeline control
  logic            adv;
  logic [N_ST-1:0] vld;

  assign adv           = !result_valid || !result_stall;
  assign reading_stall = !adv;
  assign result_valid  = vld[N_ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_ST-2:0], reading_valid};
    end
  end

  // stage 1: t^2
  logic [IN_W-1:0] s1_d1, s1_t;
  logic [47:0]     s1_t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d1 <= pressure_raw;
      s1_t  <= temperature_raw;
      s1_t2 <= temperature_raw * temperature_raw;
    end
  end

  // stage 2: coefficient products
  logic signed [24:0] s1_ts;
  logic signed [48:0] s1_t2s;
  logic [IN_W-1:0]    s2_d1;
  logic signed [34:0] s2_a1t, s2_c3t, s2_c5t;
  logic signed [58:0] s2_a2t2, s2_c4t2, s2_c6t2;

  assign s1_ts  = $signed({1'b0, s1_t});
  assign s1_t2s = $signed({1'b0, s1_t2});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d1   <= s1_d1;
      s2_a1t  <= a1 * s1_ts;
      s2_c3t  <= c3 * s1_ts;
      s2_c5t  <= c5 * s1_ts;
      s2_a2t2 <= a2 * s1_t2s;
      s2_c4t2 <= c4 * s1_t2s;
      s2_c6t2 <= c6 * s1_t2s;
    end
  end

  // stage 3: sums (temperature scaled by 3 * 2^32, ratio terms by 2^33)
  logic signed [63:0] s2_inner;
  logic signed [63:0] s3_x, s3_num, s3_den;

  assign s2_inner = (64'(s2_a1t) <<< 25) + (64'(s2_a2t2) <<< 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x   <= (64'(a0) <<< 48) + s2_inner + (s2_inner <<< 1);
      s3_num <= (64'($signed({1'b0, s2_d1})) <<< 33) + (64'(c0) <<< 42)
              + (64'(s2_c3t) <<< 24) + 64'(s2_c4t2);
      s3_den <= (64'(c1) <<< 44) + (64'(s2_c5t) <<< 25) + (64'(s2_c6t2) <<< 1);
    end
  end

  // stage 4: magnitudes
  logic [63:0]      s3_xm, s3_nm, s3_dm;
  logic [29:0]      s4_u;
  logic             s4_xneg, s4_qneg, s4_dz;
  logic [NUM_W-1:0] s4_nm;
  logic [DEN_W-1:0] s4_dm;

  assign s3_xm = s3_x[63]   ? 64'(-s3_x)   : 64'(s3_x);
  assign s3_nm = s3_num[63] ? 64'(-s3_num) : 64'(s3_num);
  assign s3_dm = s3_den[63] ? 64'(-s3_den) : 64'(s3_den);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_xneg <= s3_x[63];
      s4_u    <= 30'((s3_xm + HALF3) >> 32);
      s4_nm   <= s3_nm[NUM_W-1:0];
      s4_dm   <= s3_dm[DEN_W-1:0];
      s4_qneg <= s3_num[63] ^ s3_den[63];
      s4_dz   <= (s3_den == 64'sd0);
    end
  end

  // stage 5: temperature /3, quotient range check
  logic [60:0]      s4_tprod;
  logic [28:0]      s5_tq;
  logic             s5_xneg, s5_qneg, s5_dz, s5_ovf;
  logic [NUM_W-1:0] s5_nm;
  logic [DEN_W-1:0] s5_dm;

  assign s4_tprod = s4_u * RECIP3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_tq   <= s4_tprod[60:32];
      s5_xneg <= s4_xneg;
      s5_nm   <= s4_nm;
      s5_dm   <= s4_dm;
      s5_qneg <= s4_qneg;
      s5_dz   <= s4_dz;
      s5_ovf  <= {7'd0, s4_nm} >= {s4_dm, 8'd0};
    end
  end

  // divider: one quotient bit per stage, divisor held at dm * 2^7
  logic [DIVR_W-1:0] dr [DIV_STEPS];
  logic [DIVD_W-1:0] dd [DIV_STEPS];
  logic [Q_W-1:0]    dq [DIV_STEPS];
  div_side_t         ds [DIV_STEPS];

  logic [DIVR_W-1:0] ri [DIV_STEPS];
  logic [DIVR_W-1:0] rn [DIV_STEPS];
  logic [DIVD_W-1:0] di [DIV_STEPS];
  logic [Q_W-1:0]    qi [DIV_STEPS];
  div_side_t         si [DIV_STEPS];
  logic              ge [DIV_STEPS];
  div_side_t         side0;

  always_comb begin
    side0.temp = s5_xneg ? -$signed({3'd0, s5_tq}) : $signed({3'd0, s5_tq});
    side0.qneg = s5_qneg;
    side0.dz   = s5_dz;
    side0.ovf  = s5_ovf;
    ri[0] = {7'd0, s5_nm};
    di[0] = {s5_dm, 7'd0};
    qi[0] = '0;
    si[0] = side0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      ri[k] = dr[k-1];
      di[k] = dd[k-1];
      qi[k] = dq[k-1];
      si[k] = ds[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      ge[k] = ri[k] >= {1'b0, di[k]};
      rn[k] = ge[k] ? ri[k] - {1'b0, di[k]} : ri[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        dr[k] <= {rn[k][DIVR_W-2:0], 1'b0};
        dd[k] <= di[k];
        dq[k] <= {qi[k][Q_W-2:0], ge[k]};
        ds[k] <= si[k];
      end
    end
  end

  // post 1: round quotient to Q7.24, saturate
  logic [Q_W-1:0]    qmag;
  logic signed [31:0] y_c;
  logic              y_sat_c;
  div_side_t         dl;
  post_side_t        ps1, ps2, ps3, ps4, ps5, ps6, ps7, ps8, ps9;

  assign dl   = ds[DIV_STEPS-1];
  assign qmag = 33'((34'(dq[DIV_STEPS-1]) + 34'd1) >> 1);

  always_comb begin
    y_sat_c = 1'b0;
    if (dl.ovf) begin
      y_sat_c = 1'b1;
      y_c     = dl.qneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!dl.qneg && qmag > 33'h0_7fff_ffff) begin
      y_sat_c = 1'b1;
      y_c     = 32'sh7fff_ffff;
    end else if (dl.qneg && qmag > 33'h0_8000_0000) begin
      y_sat_c = 1'b1;
      y_c     = 32'sh8000_0000;
    end else begin
      y_c = dl.qneg ? 32'(-qmag) : qmag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ps1.temp <= dl.temp;
      ps1.y    <= y_c;
      ps1.p    <= '0;
      ps1.dz   <= dl.dz;
      ps1.sat  <= y_sat_c;
    end
  end

  // post 2..6: p = y + c2 * round(y * (y - 1)) / 2^15
  logic signed [63:0] p2_zp;
  logic signed [40:0] p3_z;
  logic signed [50:0] p4_cz;
  logic signed [34:0] p5_w;
  sat_t               p_sat_c;

  assign p_sat_c = sat32(64'(ps5.y) + 64'(p5_w));

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_zp <= ps1.y * (ps1.y - Y_ONE);
      ps2   <= ps1;
      p3_z  <= 41'(rnd_shr(p2_zp, 24));
      ps3   <= ps2;
      p4_cz <= c2 * p3_z;
      ps4   <= ps3;
      p5_w  <= 35'(rnd_shr(64'(p4_cz), 15));
      ps5   <= ps4;
      ps6.temp <= ps5.temp;
      ps6.y    <= ps5.y;
      ps6.p    <= p_sat_c.val;
      ps6.dz   <= ps5.dz;
      ps6.sat  <= ps5.sat | p_sat_c.flag;
    end
  end

  // post 7..9: (10p - 2^24) * full scale / 2^27
  logic signed [36:0] p7_e;
  logic signed [61:0] p8_pe;
  logic signed [34:0] p9_pr;
  sat_t               sc_sat_c;

  assign sc_sat_c = sat32(64'(p9_pr));

  always_ff @(posedge clk) begin
    if (adv) begin
      p7_e  <= (37'(ps6.p) <<< 3) + (37'(ps6.p) <<< 1) - E_OFF;
      ps7   <= ps6;
      p8_pe <= p7_e * $signed({1'b0, fsp});
      ps8   <= ps7;
      p9_pr <= 35'(rnd_shr(64'(p8_pe), 27));
      ps9   <= ps8;
    end
  end

  // post 10: result register
  always_ff @(posedge clk) begin
    if (adv) begin
      temperature <= ps9.temp;
      if (ps9.dz) begin
        ratio_y             <= '0;
        normalised_pressure <= '0;
        scaled_pressure     <= '0;
        status              <= STAT_ZERO;
      end else begin
        ratio_y             <= ps9.y;
        normalised_pressure <= ps9.p;
        scaled_pressure     <= sc_sat_c.val;
        status              <= (ps9.sat || sc_sat_c.flag) ? STAT_SAT : STAT_OK;
      end
    end
  end

  `PSCC_ASSERT_IMPLY(a_zero_den_clear, result_valid && status == STAT_ZERO, ratio_y == 32'sd0 && normalised_pressure == 32'sd0 && scaled_pressure == 32'sd0, "zero denominator item with nonzero result")
  `PSCC_ASSERT_NEXT(a_frozen_under_stall, result_valid && result_stall, $stable(vld) && $stable(ratio_y), "pipeline moved while result stalled")
  `PSCC_ASSERT_IMPLY(a_quot_ovf_sat, vld[DIV_LAST] && dl.ovf && !dl.dz, y_sat_c, "quotient overflow not saturated")

endmodule

[dv/testbench.sv]
// Testbench for pressure_sensor_compensation_core: random and directed reading items,
// checked against a bit-exact predictor in a scoreboard class. Depends on pscc_pkg.
`timescale 1ns / 1ps

module testbench;
  import pscc_pkg::*;

  typedef struct {
    logic signed [31:0] temp;
    logic signed [31:0] y;
    logic signed [31:0] p;
    logic signed [31:0] sp;
    logic [1:0]         stat;
  } comp_result_t;

  class result_board;
    logic [15:0] prom [N_PROM];
    logic [23:0] fsp;
    comp_result_t pending [$];
    int errors;

    function new();
      foreach (prom[i]) prom[i] = '0;
      fsp = FSP_RESET;
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [23:0] v);
      if (idx < N_PROM) prom[idx] = v[15:0];
      else fsp = v;
    endfunction

    function longint coef(int a, int sh, int len);
      logic [31:0] w;
      longint v;
      w = {prom[a], prom[a+1]};
      v = longint'((w >> sh) & ((32'd1 << len) - 1));
      if (v[len-1]) v -= longint'(1) << len;
      return v;
    endfunction

    function longint rnd_div(longint n, longint unsigned d);
      longint unsigned m;
      m = n < 0 ? -n : n;
      m = (m + d / 2) / d;
      return n < 0 ? -longint'(m) : longint'(m);
    endfunction

    function logic signed [31:0] clamp(longint v, inout bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    function void note(logic [23:0] d1r, logic [23:0] d2r);
      longint d1, t, t2, c0, c1, c2, c3, c4, c5, c6, a0, a1, a2, x, num, den;
      longint y, z, p, pr;
      longint unsigned nm, dm, q, r, mag;
      bit sat, neg;
      comp_result_t e;
      d1 = d1r;
      t = d2r;
      t2 = t * t;
      c0 = coef(0, 18, 14);
      c1 = coef(0, 4, 14);
      c2 = coef(1, 10, 10);
      c3 = coef(2, 16, 10);
      c4 = coef(3, 22, 10);
      c5 = coef(3, 12, 10);
      c6 = coef(4, 18, 10);
      a0 = coef(4, 8, 10);
      a1 = coef(5, 14, 10);
      a2 = coef(5, 4, 10);
      sat = 0;
      x = a0 * (longint'(1) << 48) + 3 * (a1 * t * (longint'(1) << 25) + 2 * a2 * t2);
      e.temp = clamp(rnd_div(x, longint'(3) << 32), sat);
      num = d1 * (longint'(1) << 33) + c0 * (longint'(1) << 42)
          + c3 * t * (longint'(1) << 24) + c4 * t2;
      den = c1 * (longint'(1) << 44) + c5 * t * (longint'(1) << 25) + 2 * c6 * t2;
      if (den == 0) begin
        e.y = 0;
        e.p = 0;
        e.sp = 0;
        e.stat = STAT_ZERO;
      end else begin
        neg = (num < 0) != (den < 0);
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        q = nm / dm;
        r = nm % dm;
        if (q >= 256) mag = longint'(1) << 33;
        else begin
          for (int i = 0; i < 25; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= dm) begin
              r -= dm;
              q |= 1;
            end
          end
          mag = (q + 1) >> 1;
        end
        e.y = clamp(neg ? -longint'(mag) : longint'(mag), sat);
        y = e.y;
        z = rnd_div(y * (y - (longint'(1) << 24)), longint'(1) << 24);
        e.p = clamp(y + rnd_div(c2 * z, longint'(1) << 15), sat);
        p = e.p;
        pr = rnd_div((10 * p - (longint'(1) << 24)) * longint'(fsp), longint'(1) << 27);
        e.sp = clamp(pr, sat);
        e.stat = sat ? STAT_SAT : STAT_OK;
      end
      pending.push_back(e);
    endfunction

    function void check(comp_result_t a);
      comp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item, temperature %h", $time, a.temp);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.temp !== e.temp) begin
        $display("%0t: temperature exp %h got %h", $time, e.temp, a.temp);
        errors++;
      end
      if (a.y !== e.y) begin
        $display("%0t: ratio_y exp %h got %h", $time, e.y, a.y);
        errors++;
      end
      if (a.p !== e.p) begin
        $display("%0t: normalised_pressure exp %h got %h", $time, e.p, a.p);
        errors++;
      end
      if (a.sp !== e.sp) begin
        $display("%0t: scaled_pressure exp %h got %h", $time, e.sp, a.sp);
        errors++;
      end
      if (a.stat !== e.stat) begin
        $display("%0t: status exp %0d got %0d", $time, e.stat, a.stat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic reading_valid = 0;
  logic reading_stall;
  logic [IN_W-1:0] pressure_raw = '0;
  logic [IN_W-1:0] temperature_raw = '0;
  logic result_valid;
  logic result_stall = 0;
  logic signed [OUT_W-1:0] temperature, ratio_y, normalised_pressure, scaled_pressure;
  logic [1:0] status;

  result_board sb = new();
  int items_sent = 0;
  int stuck = 0;
  int hold_left = 0;
  bit held = 0;

  pressure_sensor_compensation_core dut (.*);

  always #1 clk = ~clk;

  function automatic bit calm();
    return items_sent >= 1000 && items_sent < 1200;
  endfunction

  // receiver: random stalls, one long hold-off
  always @(negedge clk) begin
    if (!held && items_sent == 400) begin
      held = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1;
    end else result_stall <= !calm() && $urandom_range(99) < 13;
  end

  always @(posedge clk) begin
    comp_result_t a;
    if (!rst && result_valid && !result_stall) begin
      a.temp = temperature;
      a.y = ratio_y;
      a.p = normalised_pressure;
      a.sp = scaled_pressure;
      a.stat = status;
      sb.check(a);
    end
    if ((reading_valid && !reading_stall) || (result_valid && !result_stall)) stuck = 0;
    else stuck++;
    if (stuck > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [23:0] v);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic send_reading(logic [23:0] d1, logic [23:0] d2);
    while (!calm() && $urandom_range(99) < 13) begin
      reading_valid <= 0;
      @(negedge clk);
    end
    reading_valid <= 1;
    pressure_raw <= d1;
    temperature_raw <= d2;
    do @(posedge clk); while (reading_stall);
    sb.note(d1, d2);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    reading_valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(7))
      0: return 24'h0;
      1: return 24'hffffff;
      2: return 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic set_config(int kind);
    for (int i = 0; i < N_PROM; i++)
      case (kind)
        1: write_reg(i, 24'hffff);
        2: write_reg(i, (i % 2) ? 24'h8000 : 24'h7fff);
        3: write_reg(i, (i % 2) ? 24'h7fff : 24'h8000);
        default: write_reg(i, 24'($urandom & 32'hffff));
      endcase
    case (kind)
      1: write_reg(REG_FSP, 24'h0);
      2: write_reg(REG_FSP, 24'hffffff);
      default: write_reg(REG_FSP, ($urandom_range(1) != 0) ? 24'($urandom) : FSP_RESET);
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // reset calibration: zero denominator everywhere
    send_reading(24'h0, 24'h0);
    send_reading(24'hffffff, 24'hffffff);
    send_reading(24'hffffff, 24'h0);
    send_reading(24'h0, 24'hffffff);
    drain();
    set_config(0);
    for (int i = 0; i < 16; i++)
      send_reading((i & 1) ? 24'hffffff : 24'h0, (i & 2) ? 24'hffffff : 24'($urandom));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_config(ph < 4 ? ph : 0);
      for (int i = 0; i < 220; i++) send_reading(pick24(), pick24());
      drain();
    end
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
